FILE: rtl/core/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, clk, rst_n, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next clock edge outside of reset.
`define ASSERT_NEXT(label, ante, cons, clk, rst_n, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Types and constants shared by the triangle unit normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned FracW  = 14;
  localparam int unsigned OutW   = 16;
  // Edge, cross and square widths.
  localparam int unsigned EdgeW  = CoordW + 1;
  localparam int unsigned CrossW = 2 * EdgeW + 1;
  localparam int unsigned MagW   = CrossW - 1;
  localparam int unsigned SqW    = 2 * MagW;
  localparam int unsigned SumW   = SqW + 2;
  // Digit steps per component: bits FracW down to 0.
  localparam int unsigned Steps  = FracW + 1;
  localparam int unsigned QW     = FracW + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
  } tun_req_t;

  typedef struct packed {
    logic signed [OutW-1:0] normal_x;
    logic signed [OutW-1:0] normal_y;
    logic signed [OutW-1:0] normal_z;
    logic                   degenerate;
  } tun_rsp_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           pos;
    logic [SumW-1:0]      sum;
    logic                 zero;
  } tun_job_t;

endpackage

`default_nettype wire

FILE: rtl/core/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Forms edges, the cross product and its squared length, two stages deep.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_front import tun_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire tun_req_t req_i,
  output logic          valid_o,
  output tun_job_t      job_o
);

  logic signed [CrossW-1:0]  cx_q, cy_q, cz_q;
  logic                      v1_q;
  logic signed [EdgeW-1:0]   e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [2*EdgeW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [CrossW-1:0]  cx_d, cy_d, cz_d;
  logic [MagW-1:0]           mx, my, mz;
  logic [SqW-1:0]            sqx, sqy, sqz;
  tun_job_t                  job_d;

  // Edge vectors and cross product.
  always_comb begin
    e1x = EdgeW'(req_i.v1_x) - EdgeW'(req_i.v0_x);
    e1y = EdgeW'(req_i.v1_y) - EdgeW'(req_i.v0_y);
    e1z = EdgeW'(req_i.v1_z) - EdgeW'(req_i.v0_z);
    e2x = EdgeW'(req_i.v2_x) - EdgeW'(req_i.v0_x);
    e2y = EdgeW'(req_i.v2_y) - EdgeW'(req_i.v0_y);
    e2z = EdgeW'(req_i.v2_z) - EdgeW'(req_i.v0_z);
    p_yz = e1y * e2z;
    p_zy = e1z * e2y;
    p_zx = e1z * e2x;
    p_xz = e1x * e2z;
    p_xy = e1x * e2y;
    p_yx = e1y * e2x;
    cx_d = CrossW'(p_yz) - CrossW'(p_zy);
    cy_d = CrossW'(p_zx) - CrossW'(p_xz);
    cz_d = CrossW'(p_xy) - CrossW'(p_yx);
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    cz_q <= cz_d;
  end

  // Magnitudes, signs and squared length.
  always_comb begin
    mx = MagW'(cx_q[CrossW-1] ? -cx_q : cx_q);
    my = MagW'(cy_q[CrossW-1] ? -cy_q : cy_q);
    mz = MagW'(cz_q[CrossW-1] ? -cz_q : cz_q);
    sqx = mx * mx;
    sqy = my * my;
    sqz = mz * mz;
    job_d.mag  = {mz, my, mx};
    job_d.pos  = {cz_q > 0, cy_q > 0, cx_q > 0};
    job_d.sum  = SumW'(sqx) + SumW'(sqy) + SumW'(sqz);
    job_d.zero = (mx == '0) && (my == '0) && (mz == '0);
  end

  always_ff @(posedge clk_i) job_o <= job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tun_queue.sv
// ----------------------------------------------------------------------------
// tun_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tun_queue import tun_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire tun_job_t data_i,
  input  wire logic     pop_i,
  output logic          valid_o,
  output tun_job_t      data_o,
  output logic [1:0]    count_o
);

  tun_job_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `ASSERT_CLK(a_no_overflow, !(push_i && !pop_i && cnt_q == 2'd2), clk_i, rst_ni, "queue overflow")
  `ASSERT_CLK(a_no_underflow, !(pop_i && cnt_q == 2'd0), clk_i, rst_ni, "queue underflow")

endmodule

`default_nettype wire

FILE: rtl/core/tun_back.sv
// ----------------------------------------------------------------------------
// tun_back
// Pipelined digit-by-digit rounding of each component against the length.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tun_back import tun_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire tun_job_t job_i,
  output logic          valid_o,
  output tun_rsp_t      rsp_o
);

  // q is built one bit per stage; the test is (2t-1)^2*S <= c^2*4^(F+1).
  // With u = 2q-1, each stage keeps a = u^2*S and b = u*S, so a candidate
  // bit only needs shifts and adds: (u+2^(k+1))^2*S = a + b*2^(k+2) + S*4^(k+1).
  localparam int unsigned LhsW = 2 * (QW + 1) + SumW;
  localparam logic [QW-1:0] Lim = QW'(1) << FracW;

  logic                 vld_q [Steps+1];
  tun_job_t             job_q [Steps+1];
  logic [2:0][QW-1:0]   q_q   [Steps+1];
  logic [2:0][LhsW-1:0] rhs_q [Steps];
  logic [2:0][LhsW-1:0] a_q   [Steps];
  logic [2:0][LhsW-1:0] b_q   [Steps];
  tun_rsp_t             rsp_d;

  assign vld_q[0] = valid_i;
  assign job_q[0] = job_i;
  assign q_q[0]   = '0;

  // Bound c^2*4^(F+1) and the start values for u = -1.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [SqW-1:0] sq;
      sq = job_i.mag[c] * job_i.mag[c];
      rhs_q[0][c] = LhsW'(sq) << (2 * FracW + 2);
      a_q[0][c]   = LhsW'(job_i.sum);
      b_q[0][c]   = -LhsW'(job_i.sum);
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int unsigned Bit = FracW - s;
    logic [2:0][QW-1:0]   q_d;
    logic [2:0][LhsW-1:0] a_d, b_d;
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        logic [QW-1:0]   t;
        logic [LhsW-1:0] sum_w;
        logic [LhsW-1:0] a_t;
        t = q_q[s][c] | (QW'(1) << Bit);
        sum_w = LhsW'(job_q[s].sum);
        a_t = a_q[s][c] + (b_q[s][c] << (Bit + 2)) + (sum_w << (2 * Bit + 2));
        q_d[c] = q_q[s][c];
        a_d[c] = a_q[s][c];
        b_d[c] = b_q[s][c];
        if (t <= Lim && a_t <= rhs_q[s][c]) begin
          q_d[c] = t;
          a_d[c] = a_t;
          b_d[c] = b_q[s][c] + (sum_w << (Bit + 1));
        end
      end
    end
    always_ff @(posedge clk_i) begin
      job_q[s+1] <= job_q[s];
      q_q[s+1]   <= q_d;
    end
    if (s + 1 < Steps) begin : g_fwd
      always_ff @(posedge clk_i) begin
        rhs_q[s+1] <= rhs_q[s];
        a_q[s+1]   <= a_d;
        b_q[s+1]   <= b_d;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else vld_q[s+1] <= vld_q[s];
    end
  end

  // Sign and degenerate handling.
  always_comb begin
    logic [2:0][OutW-1:0] r;
    for (int c = 0; c < 3; c++) begin
      r[c] = job_q[Steps].zero ? '0 :
             (job_q[Steps].pos[c] ? OutW'(-OutW'(q_q[Steps][c])) : OutW'(q_q[Steps][c]));
    end
    rsp_d.normal_x   = r[0];
    rsp_d.normal_y   = r[1];
    rsp_d.normal_z   = r[2];
    rsp_d.degenerate = job_q[Steps].zero;
  end

  assign valid_o = vld_q[Steps];
  assign rsp_o   = rsp_d;

  `ASSERT_CLK(a_degen_zero, !(valid_o && rsp_o.degenerate) || (rsp_o.normal_x == '0), clk_i, rst_ni, "degenerate result not zero")

endmodule

`default_nettype wire

FILE: rtl/core/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle in signed Q1.14.
// ----------------------------------------------------------------------------
// A request is taken each cycle that start is high; busy stays low, so
// one triangle per clock is sustained. The result appears on rsp_o with
// done_o high for one cycle, after it has passed through two front stages,
// the queue register and one pipeline stage per result bit of the
// rounding unit. The receiver cannot stall, so the queue never fills.
`default_nettype none

module triangle_unit_normal import tun_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire tun_req_t req_i,
  output logic          done_o,
  output tun_rsp_t      rsp_o
);

  logic       fv, qv;
  tun_job_t   fjob, qjob;
  logic [1:0] qcnt;
  logic       bv;
  tun_rsp_t   brsp;

  assign busy = qcnt == 2'd2;

  tun_front u_front (
    .clk_i, .rst_ni, .valid_i(start && !busy), .req_i,
    .valid_o(fv), .job_o(fjob)
  );

  tun_queue u_queue (
    .clk_i, .rst_ni, .push_i(fv), .data_i(fjob), .pop_i(qv),
    .valid_o(qv), .data_o(qjob), .count_o(qcnt)
  );

  tun_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .job_i(qjob),
    .valid_o(bv), .rsp_o(brsp)
  );

  assign done_o = bv;
  assign rsp_o  = brsp;

endmodule

`default_nettype wire
